>>> design/wgr_pkg.sv
`default_nettype none

package wgr_pkg;

    // ring depth and derived widths
    localparam int MAX_WINDOW = 180;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SIZE_W     = IDX_W + 1;

    // accepted leg distance range, meters
    localparam int DIST_MIN = 3;
    localparam int DIST_MAX = 150;

    // highest ratio that still counts as valid
    localparam int RATIO_LIMIT = 200;

    // restoring divider: 15 bit sum times 16 gives a 19 bit dividend
    localparam int SUM_W     = 15;
    localparam int DIVD_W    = SUM_W + 4;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_MODE = 2'd0;
    localparam logic [1:0] CFG_USE_ENERGY  = 2'd1;

    // ratio status codes
    localparam logic [1:0] STATUS_VALID   = 2'd0;
    localparam logic [1:0] STATUS_UNAVAIL = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    typedef struct packed {
        logic        [15:0] flown_m;
        logic signed [15:0] height;
        logic signed [15:0] energy_height;
    } t_in_item;

    typedef struct packed {
        logic signed [19:0] ratio_x16;
        logic        [1:0]  ratio_status;
    } t_out_item;

    typedef struct packed {
        logic        [7:0]  flown;
        logic signed [15:0] height;
        logic signed [15:0] energy;
    } t_ring_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_READ_NEW,
        S_SELECT,
        S_DIVIDE,
        S_DONE
    } t_state;

    // window length for a mode code, capped at the ring depth
    function automatic logic [SIZE_W-1:0] window_length(input logic [2:0] mode);
        int len;
        case (mode)
            3'd0:    len = 15;
            3'd1:    len = 30;
            3'd2:    len = 60;
            3'd3:    len = 90;
            3'd4:    len = 120;
            3'd5:    len = 180;
            default: len = 3;
        endcase
        if (len > MAX_WINDOW) begin
            len = MAX_WINDOW;
        end
        return SIZE_W'(len);
    endfunction

endpackage

`default_nettype wire

>>> design/windowed_glide_ratio.sv
`default_nettype none

// Windowed glide ratio. One sample (leg distance, altitude, energy altitude)
// goes in per transfer and exactly one result comes out per sample: the
// distance summed over the last N accepted samples (N = 15, 30, 60, 90, 120 or
// 180 by window_mode, 3 for the unused codes) divided by the altitude lost
// from the oldest ring entry to the newest, times 16 and truncated toward zero.
// Leg distances outside 3..150 m are not stored but still produce a result
// from the ring as it stands. Status 0 is valid, 1 means too few entries and
// 2 means a zero drop or, for a positive drop, a ratio above 200; the ratio
// reads 0 unless valid. Writing window_mode empties the window. An item is
// handled one at a time through a ring memory with one read and one write
// port (read, write back, read oldest, read newest), then, when the ratio is
// valid, a 19-step restoring divider; the next input is taken only once the
// result has been loaded into the output register. A finished result sits in
// an output register, so the next input is taken while it waits to be
// collected.
module windowed_glide_ratio (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire wgr_pkg::t_in_item     i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output wgr_pkg::t_out_item         o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [2:0]            i_cfg_data
);

    localparam int IDX_W  = wgr_pkg::IDX_W;
    localparam int SIZE_W = wgr_pkg::SIZE_W;

    // ring memory: distance, height and energy altitude share one entry
    wgr_pkg::t_ring_entry r_ring [wgr_pkg::MAX_WINDOW];
    wgr_pkg::t_ring_entry r_rd_data;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;

    // sequencer
    wgr_pkg::t_state r_state, n_state;

    // configuration and window state
    logic [SIZE_W-1:0]          r_win_size;
    logic                       r_use_energy;
    logic [IDX_W-1:0]           r_newest;
    logic                       r_has_entry;
    logic                       r_ring_full;
    logic [wgr_pkg::SUM_W-1:0]  r_sum;
    logic [1:0]                 r_reject;

    // captured sample
    wgr_pkg::t_ring_entry r_sample;
    logic                 r_keep;
    wgr_pkg::t_ring_entry r_old;

    // divider
    logic [wgr_pkg::DIVD_W-1:0] r_quo;
    logic [16:0]                r_rem;
    logic [15:0]                r_div;
    logic                       r_neg;
    logic [wgr_pkg::CNT_W-1:0]  r_cnt;
    logic [1:0]                 r_status;

    // output register
    logic                r_out_valid;
    wgr_pkg::t_out_item  r_out;

    // control from the sequencer
    logic in_xfer;
    logic do_update;
    logic save_old;
    logic do_select;
    logic do_step;
    logic load_out;

    // ---- sample classification at the input transfer ----
    logic              dist_ok;
    logic [SIZE_W-1:0] nxt_idx;
    logic              wrap;
    logic [IDX_W-1:0]  acc_idx;

    assign dist_ok = (i_in_data.flown_m >= 16'(wgr_pkg::DIST_MIN))
                  && (i_in_data.flown_m <= 16'(wgr_pkg::DIST_MAX));
    assign nxt_idx = r_has_entry ? ({1'b0, r_newest} + SIZE_W'(1)) : '0;
    assign wrap    = (nxt_idx >= r_win_size);
    assign acc_idx = wrap ? '0 : nxt_idx[IDX_W-1:0];

    // ---- oldest entry and availability ----
    logic [SIZE_W-1:0] nw_plus1;
    logic [IDX_W-1:0]  old_addr;
    logic              avail;

    assign nw_plus1 = {1'b0, r_newest} + SIZE_W'(1);
    assign old_addr = (r_ring_full && (nw_plus1 < r_win_size)) ? nw_plus1[IDX_W-1:0] : '0;
    assign avail    = r_has_entry && (r_ring_full || (r_newest != '0));

    // ---- altitude drop, oldest minus newest ----
    logic               sel_energy;
    logic signed [16:0] drop;
    logic        [15:0] drop_mag;
    logic        [23:0] limit;
    logic               too_high;

    assign sel_energy = r_use_energy && (r_old.energy > 16'sd0) && (r_rd_data.energy > 16'sd0);
    assign drop = sel_energy
                ? (17'(r_old.energy) - 17'(r_rd_data.energy))
                : (17'(r_old.height) - 17'(r_rd_data.height));
    assign drop_mag = drop[16] ? 16'(-drop) : drop[15:0];
    // exact compare before truncation: sum > 200 * drop
    assign limit    = 24'(wgr_pkg::RATIO_LIMIT) * 24'(drop_mag);
    assign too_high = 24'(r_sum) > limit;

    // ---- divider step ----
    logic [16:0] rem_sh;
    logic        rem_ge;

    assign rem_sh = {r_rem[15:0], r_quo[wgr_pkg::DIVD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_div};

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wgr_pkg::S_IDLE:     if (i_in_valid) n_state = wgr_pkg::S_UPDATE;
            wgr_pkg::S_UPDATE:   n_state = wgr_pkg::S_READ_NEW;
            wgr_pkg::S_READ_NEW: n_state = wgr_pkg::S_SELECT;
            wgr_pkg::S_SELECT: begin
                if (!avail || (drop == 17'sd0) || (!drop[16] && too_high)) begin
                    n_state = wgr_pkg::S_DONE;
                end else begin
                    n_state = wgr_pkg::S_DIVIDE;
                end
            end
            wgr_pkg::S_DIVIDE: begin
                if (r_cnt == wgr_pkg::CNT_W'(wgr_pkg::DIV_STEPS - 1)) n_state = wgr_pkg::S_DONE;
            end
            wgr_pkg::S_DONE:     if (!r_out_valid || i_out_ready) n_state = wgr_pkg::S_IDLE;
            default:             n_state = wgr_pkg::S_IDLE;
        endcase
    end

    // ---- sequencer outputs ----
    always_comb begin
        o_in_ready = 1'b0;
        do_update  = 1'b0;
        save_old   = 1'b0;
        do_select  = 1'b0;
        do_step    = 1'b0;
        load_out   = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = r_newest;
        unique case (r_state)
            wgr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                rd_addr    = acc_idx;      // slot about to be overwritten
            end
            wgr_pkg::S_UPDATE: begin
                do_update = 1'b1;
                mem_we    = r_keep;
                rd_addr   = old_addr;
            end
            wgr_pkg::S_READ_NEW: begin
                save_old = 1'b1;
                rd_addr  = r_newest;
            end
            wgr_pkg::S_SELECT: do_select = 1'b1;
            wgr_pkg::S_DIVIDE: do_step   = 1'b1;
            wgr_pkg::S_DONE:   load_out  = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign in_xfer = o_in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wgr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- ring memory ----
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_newest] <= r_sample;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // ---- window control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size   <= wgr_pkg::window_length(3'd2);
            r_use_energy <= 1'b0;
            r_newest     <= '0;
            r_has_entry  <= 1'b0;
            r_ring_full  <= 1'b0;
            r_sum        <= '0;
            r_reject     <= '0;
            r_keep       <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == wgr_pkg::CFG_WINDOW_MODE) begin
                r_win_size  <= wgr_pkg::window_length(i_cfg_data);
                r_sum       <= '0;
                r_newest    <= '0;
                r_has_entry <= 1'b0;
                r_ring_full <= 1'b0;
            end else if (i_cfg_index == wgr_pkg::CFG_USE_ENERGY) begin
                r_use_energy <= i_cfg_data[0];
            end
        end else begin
            if (in_xfer) begin
                r_keep <= dist_ok;
                if (dist_ok) begin
                    r_reject    <= '0;
                    r_newest    <= acc_idx;
                    r_has_entry <= 1'b1;
                    if (wrap) r_ring_full <= 1'b1;
                end else begin
                    r_reject <= (r_reject > 2'd2) ? 2'd0 : r_reject + 2'd1;
                end
            end
            // drop the overwritten distance once the ring has wrapped
            if (do_update && r_keep) begin
                r_sum <= r_sum + wgr_pkg::SUM_W'(r_sample.flown)
                       - (r_ring_full ? wgr_pkg::SUM_W'(r_rd_data.flown) : '0);
            end
        end
    end

    // ---- datapath: sample, oldest entry, divider ----
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample.flown  <= i_in_data.flown_m[7:0];
            r_sample.height <= i_in_data.height;
            r_sample.energy <= i_in_data.energy_height;
        end
        if (save_old) begin
            r_old <= r_rd_data;
        end
        if (do_select) begin
            r_rem <= '0;
            r_div <= drop_mag;
            r_cnt <= '0;
            r_neg <= 1'b0;
            r_quo <= '0;
            if (!avail) begin
                r_status <= wgr_pkg::STATUS_UNAVAIL;
            end else if ((drop == 17'sd0) || (!drop[16] && too_high)) begin
                r_status <= wgr_pkg::STATUS_INVALID;
            end else begin
                r_status <= wgr_pkg::STATUS_VALID;
                r_neg    <= drop[16];
                r_quo    <= {r_sum, 4'b0000};
            end
        end
        if (do_step) begin
            r_cnt <= r_cnt + wgr_pkg::CNT_W'(1);
            r_rem <= rem_ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
            r_quo <= {r_quo[wgr_pkg::DIVD_W-2:0], rem_ge};
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.ratio_x16    <= r_neg ? -20'(r_quo) : 20'(r_quo);
            r_out.ratio_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
